@@ sv/mrir_pkg.sv @@
// shared types, constants and the crc helper for the input register responder
// no dependencies
`default_nettype none

package mrir_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
    localparam int MIN_FRAME   = 8;

    localparam int MAX_QTY   = 29;
    localparam int REPLY_MAX = 3 + 2 * MAX_QTY + 2;
    localparam int POS_W     = $clog2(REPLY_MAX);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

    localparam logic [7:0]  UNIT_ID_RST    = 8'd1;
    localparam logic [15:0] GAP_TICKS_RST  = 16'd3645;
    localparam logic [15:0] VALUE_WRAP_RST = 16'd400;
    localparam logic [15:0] REPLY_VAL_RST  = 16'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT_ID    = 2'd0,
        CFG_GAP_TICKS  = 2'd1,
        CFG_VALUE_WRAP = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DECIDE,
        ST_REPLY
    } t_back_state;

    // closed frame handed from front to back
    typedef struct packed {
        logic [LEN_W-1:0] len;
    } t_job;

    // back to front: frame memory read address and buffer release
    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              release_buf;
    } t_back_ctl;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

@@ sv/mrir_in_if.sv @@
// input channel: received bytes and time ticks
// depends on nothing
`default_nettype none

interface mrir_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ sv/mrir_out_if.sv @@
// output channel: reply bytes with end-of-frame flag
// depends on nothing
`default_nettype none

interface mrir_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last;

    modport source (output valid, output tx_byte, output last, input ready);
    modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

`default_nettype wire

@@ sv/mrir_front.sv @@
// front end: takes bytes and ticks, fills the frame buffer, closes frames on the gap
// depends on mrir_pkg and mrir_in_if
`default_nettype none

module mrir_front
    import mrir_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    mrir_in_if.sink                in_ch,
    input  wire logic [15:0]       i_gap_ticks,
    output logic                   o_push,
    output t_job                   o_job,
    input  wire logic              i_q_full,
    input  wire t_back_ctl         i_back_ctl,
    output logic [7:0]             o_rd_data
);

    logic [7:0]       r_mem [FRAME_BYTES];
    logic [LEN_W-1:0] r_len;
    logic [15:0]      r_idle;
    logic             r_lock;
    logic [7:0]       r_rd_data;

    logic             accept;
    logic             wr_en;
    logic [15:0]      idle_inc;
    logic             close_now;

    // buffer is held while the back end walks a closed frame
    assign in_ch.ready = !r_lock && !i_q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign wr_en       = accept && !in_ch.mode && (r_len < LEN_W'(FRAME_BYTES));
    assign idle_inc    = (r_idle == IDLE_MAX) ? r_idle : r_idle + 16'd1;
    assign close_now   = accept && in_ch.mode && (r_len != '0) && (idle_inc >= i_gap_ticks);

    assign o_push    = close_now;
    assign o_job.len = r_len;
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_len[ADDR_W-1:0]] <= in_ch.rx_byte;
        end
        r_rd_data <= r_mem[i_back_ctl.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_idle <= '0;
            r_lock <= 1'b0;
        end else begin
            if (accept) begin
                if (!in_ch.mode) begin
                    if (wr_en) begin
                        r_len <= r_len + LEN_W'(1);
                    end
                    r_idle <= '0;
                end else if (r_len != '0) begin
                    if (close_now) begin
                        r_len  <= '0;
                        r_idle <= '0;
                    end else begin
                        r_idle <= idle_inc;
                    end
                end
            end
            if (close_now) begin
                r_lock <= 1'b1;
            end else if (i_back_ctl.release_buf) begin
                r_lock <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/mrir_queue.sv @@
// short fifo of closed-frame jobs between front and back
// depends on mrir_pkg
`default_nettype none

module mrir_queue
    import mrir_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_push_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_pop_job,
    output logic      o_empty
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;
    assign o_pop_job = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/mrir_back.sv @@
// back end: walks a closed frame for address, function, quantity and crc,
// then streams the reply through an output register
// depends on mrir_pkg and mrir_out_if
`default_nettype none

module mrir_back
    import mrir_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_unit_id,
    input  wire logic [15:0] i_value_wrap,
    input  wire logic        i_q_empty,
    input  wire t_job        i_job,
    output logic             o_pop,
    output t_back_ctl        o_back_ctl,
    input  wire logic [7:0]  i_rd_data,
    mrir_out_if.source       out_ch
);

    t_back_state       r_state;
    t_back_state       n_state;

    logic [LEN_W-1:0]  r_n;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] n_idx;
    logic              r_dv;
    logic              n_dv;
    logic [ADDR_W-1:0] r_didx;
    logic [15:0]       r_crc;
    logic [15:0]       r_got;
    logic              r_hdr_ok;
    logic [15:0]       r_qty;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_rlen;
    logic [15:0]       r_val;
    logic [15:0]       r_reply_value;
    logic              r_ovalid;
    logic [7:0]        r_otx;
    logic              r_olast;

    logic              start_job;
    logic              start_reply;
    logic              emit;
    logic              frame_ok;
    logic [LEN_W-1:0]  didx_ext;
    logic [7:0]        tx_next;
    logic [16:0]       val_inc;
    logic              out_free;

    assign didx_ext = {{(LEN_W-ADDR_W){1'b0}}, r_didx};
    assign out_free = !r_ovalid || out_ch.ready;
    assign frame_ok = r_hdr_ok && (r_crc == r_got) && (r_qty != 16'd0)
                      && (r_qty <= 16'(MAX_QTY));
    assign val_inc  = {1'b0, r_reply_value} + 17'd1;

    assign out_ch.valid   = r_ovalid;
    assign out_ch.tx_byte = r_otx;
    assign out_ch.last    = r_olast;

    // reply byte at the current position
    always_comb begin
        if (r_pos == POS_W'(0)) begin
            tx_next = i_unit_id;
        end else if (r_pos == POS_W'(1)) begin
            tx_next = FUNC_READ_INPUT;
        end else if (r_pos == POS_W'(2)) begin
            tx_next = {r_qty[6:0], 1'b0};
        end else if (r_pos == POS_W'(3)) begin
            tx_next = r_val[15:8];
        end else if (r_pos == POS_W'(4)) begin
            tx_next = r_val[7:0];
        end else if (r_pos == r_rlen - POS_W'(2)) begin
            tx_next = r_crc[7:0];
        end else if (r_pos == r_rlen - POS_W'(1)) begin
            tx_next = r_crc[15:8];
        end else begin
            tx_next = 8'h00;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_dv        = 1'b0;
        o_pop       = 1'b0;
        start_job   = 1'b0;
        start_reply = 1'b0;
        emit        = 1'b0;
        o_back_ctl.rd_addr     = r_idx;
        o_back_ctl.release_buf = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_job.len < LEN_W'(MIN_FRAME)) begin
                        // too short to be a request
                        o_back_ctl.release_buf = 1'b1;
                    end else begin
                        start_job = 1'b1;
                        n_idx     = '0;
                        n_state   = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_dv = 1'b1;
                if ({{(LEN_W-ADDR_W){1'b0}}, r_idx} == r_n - LEN_W'(1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_back_ctl.release_buf = 1'b1;
                if (frame_ok) begin
                    start_reply = 1'b1;
                    n_state     = ST_REPLY;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_pos == r_rlen - POS_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_dv          <= 1'b0;
            r_ovalid      <= 1'b0;
            r_reply_value <= REPLY_VAL_RST;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            if (start_reply) begin
                r_reply_value <= (val_inc > {1'b0, i_value_wrap}) ? 16'd0 : val_inc[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_didx <= r_idx;
        if (start_job) begin
            r_n      <= i_job.len;
            r_crc    <= CRC_INIT;
            r_hdr_ok <= 1'b1;
        end
        // data from the frame buffer is registered, so it arrives in the cycle after its address
        if (r_dv) begin
            if (r_didx == ADDR_W'(0) && i_rd_data != i_unit_id) begin
                r_hdr_ok <= 1'b0;
            end
            if (r_didx == ADDR_W'(1) && i_rd_data != FUNC_READ_INPUT) begin
                r_hdr_ok <= 1'b0;
            end
            if (r_didx == ADDR_W'(4)) begin
                r_qty[15:8] <= i_rd_data;
            end
            if (r_didx == ADDR_W'(5)) begin
                r_qty[7:0] <= i_rd_data;
            end
            if (didx_ext + LEN_W'(2) < r_n) begin
                r_crc <= crc16_update(r_crc, i_rd_data);
            end
            if (didx_ext == r_n - LEN_W'(2)) begin
                r_got[7:0] <= i_rd_data;
            end
            if (didx_ext == r_n - LEN_W'(1)) begin
                r_got[15:8] <= i_rd_data;
            end
        end
        if (start_reply) begin
            r_pos  <= '0;
            r_rlen <= POS_W'(5) + {r_qty[POS_W-2:0], 1'b0};
            r_val  <= r_reply_value;
            r_crc  <= CRC_INIT;
        end
        if (emit) begin
            r_otx   <= tx_next;
            r_olast <= (r_pos == r_rlen - POS_W'(1));
            r_pos   <= r_pos + POS_W'(1);
            if (r_pos < r_rlen - POS_W'(2)) begin
                r_crc <= crc16_update(r_crc, tx_next);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/modbus_rtu_input_register_responder_core.sv @@
// input: a tick that closes a frame stalls the input until the back end frees the buffer,
// sooner for a frame under 8 bytes, longer while an earlier reply is still going out
// the reply goes out one byte per cycle while the output is ready, 5 + 2*qty bytes
// reset: synchronous active low; clears frame length, idle count, queue, reply value (250)
// and the config registers; the frame buffer is not cleared
// depends on mrir_pkg, mrir_in_if, mrir_out_if, mrir_front, mrir_queue, mrir_back
`default_nettype none

module modbus_rtu_input_register_responder_core
    import mrir_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    mrir_in_if.sink                    i_in,
    mrir_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [7:0]  r_unit_id;
    logic [15:0] r_gap_ticks;
    logic [15:0] r_value_wrap;

    logic        push;
    t_job        push_job;
    logic        q_full;
    logic        pop;
    t_job        pop_job;
    logic        q_empty;
    t_back_ctl   back_ctl;
    logic [7:0]  rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_id    <= UNIT_ID_RST;
            r_gap_ticks  <= GAP_TICKS_RST;
            r_value_wrap <= VALUE_WRAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UNIT_ID:    r_unit_id    <= i_cfg_data[7:0];
                CFG_GAP_TICKS:  r_gap_ticks  <= i_cfg_data;
                CFG_VALUE_WRAP: r_value_wrap <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mrir_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (i_in),
        .i_gap_ticks (r_gap_ticks),
        .o_push      (push),
        .o_job       (push_job),
        .i_q_full    (q_full),
        .i_back_ctl  (back_ctl),
        .o_rd_data   (rd_data)
    );

    mrir_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_pop_job  (pop_job),
        .o_empty    (q_empty)
    );

    mrir_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_unit_id    (r_unit_id),
        .i_value_wrap (r_value_wrap),
        .i_q_empty    (q_empty),
        .i_job        (pop_job),
        .o_pop        (pop),
        .o_back_ctl   (back_ctl),
        .i_rd_data    (rd_data),
        .out_ch       (o_out)
    );

endmodule

`default_nettype wire
